FILE: design/npip_pkg.sv
// ----------------------------------------------------------------------------
// npip_pkg
// Shared types and constants of the nested phase interval profiler.
// ----------------------------------------------------------------------------
package npip_pkg;

   localparam int STAMP_W = 48;
   localparam int TOTAL_W = 64;
   localparam int COUNT_W = 48;
   localparam int DEPTH_W = 8;
   localparam int CMD_W   = 2;
   localparam int PHASE_W = 4;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_ENTER = 2'd0,
      CMD_EXIT  = 2'd1,
      CMD_ACCUM = 2'd2,
      CMD_RSVD  = 2'd3
   } cmd_type;

   // one phase's counters
   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [STAMP_W-1:0] start;
      logic [TOTAL_W-1:0] total;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] longest;
   } entry_type;

   // write request from the update logic to the phase table
   typedef struct packed {
      logic               entry_we;
      logic               start_we;
      logic               first_we;
      entry_type          entry;
      logic [STAMP_W-1:0] first_stamp;
   } tbl_wr_type;

   // flags of one result
   typedef struct packed {
      logic closed;
      logic ignored;
   } status_type;

endpackage

FILE: design/npip_update.sv
// ----------------------------------------------------------------------------
// npip_update
// Next state of the addressed phase entry for one enter, exit or
// accumulate command.
// ----------------------------------------------------------------------------
module npip_update (
   input  logic                        enable,
   input  logic                        phase_ok,
   input  npip_pkg::cmd_type           cmd,
   input  logic [npip_pkg::STAMP_W-1:0] now,
   input  logic [npip_pkg::STAMP_W-1:0] duration,
   input  npip_pkg::entry_type         cur,
   input  logic                        first_seen,
   output npip_pkg::tbl_wr_type        wr,
   output npip_pkg::status_type        status
);

   logic [npip_pkg::STAMP_W-1:0] elapsed;
   logic [npip_pkg::STAMP_W-1:0] add_val;
   logic [npip_pkg::TOTAL_W:0]   sum;
   logic                         do_add;
   npip_pkg::entry_type          nxt;

   // backward time gives a zero interval
   assign elapsed = (now >= cur.start) ? (now - cur.start) : '0;
   assign sum     = {1'b0, cur.total} +
                    {{(npip_pkg::TOTAL_W + 1 - npip_pkg::STAMP_W){1'b0}}, add_val};

   always_comb begin
      nxt            = cur;
      add_val        = '0;
      do_add         = 1'b0;
      status.closed  = 1'b0;
      status.ignored = 1'b0;
      wr.start_we    = 1'b0;
      if (!phase_ok) begin
         status.ignored = 1'b1;
      end else begin
         unique case (cmd)
            npip_pkg::CMD_ENTER: begin
               if (!enable) begin
                  status.ignored = 1'b1;
               end else begin
                  if (cur.depth == '0) begin
                     nxt.start   = now;
                     wr.start_we = 1'b1;
                  end
                  if (cur.depth != npip_pkg::DEPTH_MAX) begin
                     nxt.depth = cur.depth + 1'b1;
                  end
               end
            end
            npip_pkg::CMD_EXIT: begin
               if (!enable || cur.depth == '0) begin
                  status.ignored = 1'b1;
               end else begin
                  nxt.depth = cur.depth - 1'b1;
                  if (cur.depth == npip_pkg::DEPTH_W'(1)) begin
                     add_val = elapsed;
                     do_add  = 1'b1;
                  end
               end
            end
            npip_pkg::CMD_ACCUM: begin
               // negative duration clamps to zero
               add_val = duration[npip_pkg::STAMP_W-1] ? '0 : duration;
               do_add  = 1'b1;
            end
            npip_pkg::CMD_RSVD: begin
               status.ignored = 1'b1;
            end
            default: begin
               status.ignored = 1'b1;
            end
         endcase
      end

      if (do_add) begin
         status.closed = 1'b1;
         nxt.total = sum[npip_pkg::TOTAL_W] ? npip_pkg::TOTAL_MAX
                                            : sum[npip_pkg::TOTAL_W-1:0];
         if (cur.count != npip_pkg::COUNT_MAX) begin
            nxt.count = cur.count + 1'b1;
         end
         if (add_val > cur.longest) begin
            nxt.longest = add_val;
         end
      end

      wr.entry       = nxt;
      wr.entry_we    = phase_ok;
      wr.first_we    = do_add && !first_seen;
      wr.first_stamp = now;
   end

endmodule

FILE: design/npip_table.sv
// ----------------------------------------------------------------------------
// npip_table
// Per-phase counter registers and the first-accumulation stamp.
// ----------------------------------------------------------------------------
module npip_table #(
   parameter int NUM_PHASES = 6,
   parameter int IDX_W      = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             idx,
   input  npip_pkg::tbl_wr_type         wr,
   output npip_pkg::entry_type          rd,
   output logic                         first_seen,
   output logic [npip_pkg::STAMP_W-1:0] first_stamp
);

   logic [npip_pkg::DEPTH_W-1:0] depth_ff   [NUM_PHASES];
   logic [npip_pkg::STAMP_W-1:0] start_ff   [NUM_PHASES];
   logic [npip_pkg::TOTAL_W-1:0] total_ff   [NUM_PHASES];
   logic [npip_pkg::COUNT_W-1:0] count_ff   [NUM_PHASES];
   logic [npip_pkg::STAMP_W-1:0] longest_ff [NUM_PHASES];
   logic                         first_seen_ff;
   logic [npip_pkg::STAMP_W-1:0] first_stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PHASES; i++) begin
            depth_ff[i]   <= '0;
            total_ff[i]   <= '0;
            count_ff[i]   <= '0;
            longest_ff[i] <= '0;
         end
         first_seen_ff <= 1'b0;
      end else begin
         if (wr_en && wr.entry_we) begin
            depth_ff[idx]   <= wr.entry.depth;
            total_ff[idx]   <= wr.entry.total;
            count_ff[idx]   <= wr.entry.count;
            longest_ff[idx] <= wr.entry.longest;
         end
         if (wr_en && wr.first_we) begin
            first_seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr.entry_we && wr.start_we) begin
         start_ff[idx] <= wr.entry.start;
      end
      if (wr_en && wr.first_we) begin
         first_stamp_ff <= wr.first_stamp;
      end
   end

   always_comb begin
      rd.depth   = depth_ff[idx];
      rd.start   = start_ff[idx];
      rd.total   = total_ff[idx];
      rd.count   = count_ff[idx];
      rd.longest = longest_ff[idx];
   end

   assign first_seen  = first_seen_ff;
   assign first_stamp = first_stamp_ff;

endmodule

FILE: design/nested_phase_interval_profiler_core.sv
// ----------------------------------------------------------------------------
// nested_phase_interval_profiler_core
// Times the outermost enter/exit interval of each phase and keeps
// saturating totals, counts and longest intervals per phase.
// ----------------------------------------------------------------------------
// One item is accepted per cycle unless a held result blocks the input
// register: the item sits in the input register, the addressed phase entry
// is read, updated and written back as the item advances, and the result is
// held in an output register. The direct read-modify-write of the
// flip-flop phase table sets this rate, so items to the same phase may
// follow each other without gaps. All counters are zero after reset and
// enter/exit tracking starts disabled until csr_we writes csr_wdata = 1.
module nested_phase_interval_profiler_core #(
   parameter int NUM_PHASES = 6,
   parameter int TIME_BITS  = 48
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_we,
   input  logic        csr_wdata,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_phase,
   input  logic [47:0] req_now_ticks,
   input  logic signed [47:0] req_duration,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_total_ticks,
   output logic [47:0] rsp_interval_count,
   output logic [47:0] rsp_longest_ticks,
   output logic [7:0]  rsp_nest_depth,
   output logic        rsp_interval_closed,
   output logic        rsp_ignored,
   output logic        rsp_first_valid,
   output logic [47:0] rsp_first_time
);

   localparam int IDX_W   = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
   localparam int STAMP_B = (TIME_BITS < npip_pkg::STAMP_W) ? TIME_BITS : npip_pkg::STAMP_W;
   localparam logic [npip_pkg::STAMP_W-1:0] TIME_MASK =
      {npip_pkg::STAMP_W{1'b1}} >> (npip_pkg::STAMP_W - STAMP_B);

   logic                          enable_ff;

   // input register
   logic                          in_valid_ff;
   logic                          in_valid_in;
   npip_pkg::cmd_type             in_cmd_ff;
   logic [npip_pkg::PHASE_W-1:0]  in_phase_ff;
   logic [npip_pkg::STAMP_W-1:0]  in_now_ff;
   logic [npip_pkg::STAMP_W-1:0]  in_dur_ff;

   // result register
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [npip_pkg::TOTAL_W-1:0]  out_total_ff;
   logic [npip_pkg::COUNT_W-1:0]  out_count_ff;
   logic [npip_pkg::STAMP_W-1:0]  out_longest_ff;
   logic [npip_pkg::DEPTH_W-1:0]  out_depth_ff;
   npip_pkg::status_type          out_status_ff;
   logic                          out_first_valid_ff;
   logic [npip_pkg::STAMP_W-1:0]  out_first_time_ff;

   logic                          req_take;
   logic                          advance;
   logic                          phase_ok;
   logic [IDX_W-1:0]              idx;
   npip_pkg::entry_type           cur;
   npip_pkg::tbl_wr_type          wr;
   npip_pkg::status_type          status;
   logic                          first_seen;
   logic [npip_pkg::STAMP_W-1:0]  first_stamp;
   logic                          first_seen_new;
   logic [npip_pkg::STAMP_W-1:0]  first_stamp_new;

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   assign phase_ok = {1'b0, in_phase_ff} < (npip_pkg::PHASE_W + 1)'(NUM_PHASES);
   assign idx      = phase_ok ? in_phase_ff[IDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            enable_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= npip_pkg::cmd_type'(req_cmd);
         in_phase_ff <= req_phase;
         in_now_ff   <= req_now_ticks & TIME_MASK;
         in_dur_ff   <= req_duration;
      end
   end

   npip_table #(
      .NUM_PHASES (NUM_PHASES),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (advance),
      .idx         (idx),
      .wr          (wr),
      .rd          (cur),
      .first_seen  (first_seen),
      .first_stamp (first_stamp)
   );

   npip_update u_update (
      .enable     (enable_ff),
      .phase_ok   (phase_ok),
      .cmd        (in_cmd_ff),
      .now        (in_now_ff),
      .duration   (in_dur_ff),
      .cur        (cur),
      .first_seen (first_seen),
      .wr         (wr),
      .status     (status)
   );

   assign first_seen_new  = first_seen || wr.first_we;
   assign first_stamp_new = wr.first_we ? wr.first_stamp : first_stamp;

   always_ff @(posedge clock) begin
      if (advance) begin
         out_total_ff       <= phase_ok ? wr.entry.total   : '0;
         out_count_ff       <= phase_ok ? wr.entry.count   : '0;
         out_longest_ff     <= phase_ok ? wr.entry.longest : '0;
         out_depth_ff       <= phase_ok ? wr.entry.depth   : '0;
         out_status_ff      <= status;
         out_first_valid_ff <= first_seen_new;
         out_first_time_ff  <= first_seen_new ? first_stamp_new : '0;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_total_ticks     = out_total_ff;
   assign rsp_interval_count  = out_count_ff;
   assign rsp_longest_ticks   = out_longest_ff;
   assign rsp_nest_depth      = out_depth_ff;
   assign rsp_interval_closed = out_status_ff.closed;
   assign rsp_ignored         = out_status_ff.ignored;
   assign rsp_first_valid     = out_first_valid_ff;
   assign rsp_first_time      = out_first_time_ff;

   // input side only backs up when a held result is not taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall && in_valid_ff))
      else $error("req_stall without a blocked result");

   a_closed_not_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_interval_closed && rsp_ignored))
      else $error("result both closed and ignored");

   a_closed_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_interval_closed) |-> (rsp_interval_count != '0 && rsp_first_valid))
      else $error("closed interval with zero count or no first stamp");

   a_first_sticky: assert property (@(posedge clock) disable iff (reset)
      first_seen |=> first_seen)
      else $error("first stamp flag cleared outside reset");

endmodule

FILE: test/tb_nested_phase_interval_profiler_core.sv
// ----------------------------------------------------------------------------
// tb_nested_phase_interval_profiler_core
// Self-checking bench for the phase interval profiler. A local model keeps
// its own phase tables, predicts one report per accepted event and compares
// every report field with it. The stimulus runs directed corner events, a
// deep nesting run that saturates the depth, then random nested enter/exit
// sequences, accumulates and noise. Enable tracking is toggled between
// rounds. Both sides idle at random, and the receiver holds off for long
// stretches so the core backs up.
// ----------------------------------------------------------------------------
module tb_nested_phase_interval_profiler_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PHASES = 6;
   localparam int TIME_BITS  = 48;
   localparam int STAMP_W = npip_pkg::STAMP_W;
   localparam int TOTAL_W = npip_pkg::TOTAL_W;
   localparam int COUNT_W = npip_pkg::COUNT_W;
   localparam int DEPTH_W = npip_pkg::DEPTH_W;
   localparam int PHASE_W = npip_pkg::PHASE_W;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
   localparam logic [STAMP_W-1:0] TIME_MASK = STAMP_W'((64'd1 << TIME_BITS) - 64'd1);

   typedef struct {
      npip_pkg::cmd_type         cmd;
      logic [PHASE_W-1:0]        phase;
      logic [STAMP_W-1:0]        now_ticks;
      logic signed [STAMP_W-1:0] duration;
   } phase_event_type;

   typedef struct {
      logic [TOTAL_W-1:0] total_ticks;
      logic [COUNT_W-1:0] interval_count;
      logic [STAMP_W-1:0] longest_ticks;
      logic [DEPTH_W-1:0] nest_depth;
      logic               interval_closed;
      logic               ignored;
      logic               first_valid;
      logic [STAMP_W-1:0] first_time;
   } phase_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_we = 1'b0;
   logic                      csr_wdata = 1'b0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_cmd = '0;
   logic [3:0]                req_phase = '0;
   logic [47:0]               req_now_ticks = '0;
   logic signed [47:0]        req_duration = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [63:0]               rsp_total_ticks;
   logic [47:0]               rsp_interval_count;
   logic [47:0]               rsp_longest_ticks;
   logic [7:0]                rsp_nest_depth;
   logic                      rsp_interval_closed;
   logic                      rsp_ignored;
   logic                      rsp_first_valid;
   logic [47:0]               rsp_first_time;

   nested_phase_interval_profiler_core #(
      .NUM_PHASES (NUM_PHASES),
      .TIME_BITS  (TIME_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_phase           (req_phase),
      .req_now_ticks       (req_now_ticks),
      .req_duration        (req_duration),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_total_ticks     (rsp_total_ticks),
      .rsp_interval_count  (rsp_interval_count),
      .rsp_longest_ticks   (rsp_longest_ticks),
      .rsp_nest_depth      (rsp_nest_depth),
      .rsp_interval_closed (rsp_interval_closed),
      .rsp_ignored         (rsp_ignored),
      .rsp_first_valid     (rsp_first_valid),
      .rsp_first_time      (rsp_first_time)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // local copy of the profiler state
   logic [DEPTH_W-1:0] phase_depth   [NUM_PHASES] = '{default: '0};
   logic [STAMP_W-1:0] phase_start   [NUM_PHASES] = '{default: '0};
   logic [TOTAL_W-1:0] phase_total   [NUM_PHASES] = '{default: '0};
   logic [COUNT_W-1:0] phase_tally   [NUM_PHASES] = '{default: '0};
   logic [STAMP_W-1:0] phase_longest [NUM_PHASES] = '{default: '0};
   logic [STAMP_W-1:0] first_stamp = '0;
   logic               first_seen = 1'b0;
   logic               track_en = 1'b0;

   phase_event_type  event_queue[$];
   phase_report_type predicted_reports[$];
   phase_event_type  offered;

   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0, send_calm = 0;
   int unsigned recv_gap = 0, recv_calm = 0;
   int unsigned hold_count = 0;
   logic        hold_request = 1'b0;
   logic [STAMP_W-1:0] clock_stamp = '0;

   function automatic void add_interval(int unsigned p, logic [63:0] ticks,
                                        logic [STAMP_W-1:0] now);
      logic [TOTAL_W:0]   sum;
      logic [STAMP_W-1:0] capped;
      capped = (ticks > {16'd0, STAMP_MAX}) ? STAMP_MAX : ticks[STAMP_W-1:0];
      sum = {1'b0, phase_total[p]} + {1'b0, ticks};
      phase_total[p] = sum[TOTAL_W] ? npip_pkg::TOTAL_MAX : sum[TOTAL_W-1:0];
      if (phase_tally[p] != npip_pkg::COUNT_MAX) phase_tally[p]++;
      if (capped > phase_longest[p]) phase_longest[p] = capped;
      if (!first_seen) begin
         first_seen = 1'b1;
         first_stamp = now;
      end
   endfunction

   function automatic phase_report_type profile_update(phase_event_type ev);
      phase_report_type   rep;
      logic [STAMP_W-1:0] now;
      logic [STAMP_W-1:0] elapsed;
      int unsigned        p;
      logic               in_range;
      rep = '{default: '0};
      p = 32'(ev.phase);
      in_range = p < NUM_PHASES;
      now = ev.now_ticks & TIME_MASK;
      if (!in_range) begin
         rep.ignored = 1'b1;
      end else begin
         case (ev.cmd)
            npip_pkg::CMD_ENTER: begin
               if (!track_en) begin
                  rep.ignored = 1'b1;
               end else begin
                  if (phase_depth[p] == '0) phase_start[p] = now;
                  // depth sticks at its maximum, not reported as ignored
                  if (phase_depth[p] != npip_pkg::DEPTH_MAX) phase_depth[p]++;
               end
            end
            npip_pkg::CMD_EXIT: begin
               if (!track_en || phase_depth[p] == '0) begin
                  rep.ignored = 1'b1;
               end else begin
                  phase_depth[p]--;
                  if (phase_depth[p] == '0) begin
                     // backward time closes with zero ticks
                     elapsed = (now >= phase_start[p]) ? now - phase_start[p] : '0;
                     add_interval(p, {16'd0, elapsed}, now);
                     rep.interval_closed = 1'b1;
                  end
               end
            end
            npip_pkg::CMD_ACCUM: begin
               add_interval(p, ev.duration[STAMP_W-1] ? 64'd0 : {16'd0, ev.duration}, now);
               rep.interval_closed = 1'b1;
            end
            default: rep.ignored = 1'b1;
         endcase
         rep.total_ticks    = phase_total[p];
         rep.interval_count = phase_tally[p];
         rep.longest_ticks  = phase_longest[p];
         rep.nest_depth     = phase_depth[p];
      end
      rep.first_valid = first_seen;
      rep.first_time  = first_seen ? first_stamp : '0;
      return rep;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // mostly back to back or short gaps, a few long ones, and calm stretches
   function automatic int unsigned idle_len(inout int unsigned calm);
      int unsigned roll;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll == 0) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 2);
      if (roll < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [STAMP_W-1:0] next_stamp();
      case ($urandom_range(0, 15))
         0: clock_stamp = STAMP_W'({$urandom, $urandom});
         1: clock_stamp = clock_stamp - STAMP_W'($urandom_range(1, 500));
         default: clock_stamp = clock_stamp + STAMP_W'($urandom_range(0, 2000));
      endcase
      return clock_stamp;
   endfunction

   function automatic logic [STAMP_W-1:0] rand_duration();
      case ($urandom_range(0, 3))
         0: return STAMP_W'({$urandom, $urandom});
         1: return '0 - STAMP_W'($urandom_range(1, 1000));
         default: return STAMP_W'($urandom_range(0, 100000));
      endcase
   endfunction

   function automatic void queue_event(npip_pkg::cmd_type c, logic [PHASE_W-1:0] p,
                                       logic [STAMP_W-1:0] t, logic [STAMP_W-1:0] d);
      phase_event_type ev;
      ev.cmd = c;
      ev.phase = p;
      ev.now_ticks = t;
      ev.duration = d;
      event_queue.push_back(ev);
   endfunction

   function automatic void queue_random(int unsigned n);
      int unsigned made;
      int unsigned nest;
      logic [PHASE_W-1:0] p;
      made = 0;
      while (made < n) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               p = PHASE_W'($urandom_range(0, NUM_PHASES - 1));
               nest = $urandom_range(1, 4);
               repeat (nest) begin
                  queue_event(npip_pkg::CMD_ENTER, p, next_stamp(), rand_duration());
               end
               repeat (nest) begin
                  queue_event(npip_pkg::CMD_EXIT, p, next_stamp(), rand_duration());
               end
               made += 2 * nest;
            end
            6, 7: begin
               queue_event(npip_pkg::CMD_ACCUM, PHASE_W'($urandom_range(0, NUM_PHASES - 1)),
                           next_stamp(), rand_duration());
               made++;
            end
            default: begin
               queue_event(npip_pkg::cmd_type'(2'($urandom_range(0, 3))),
                           PHASE_W'($urandom_range(0, 15)),
                           STAMP_W'({$urandom, $urandom}), STAMP_W'({$urandom, $urandom}));
               made++;
            end
         endcase
      end
   endfunction

   task automatic csr_write(logic value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      track_en = value;
   endtask

   // checked at the falling edge, after all rising edge activity settled
   task automatic wait_drained();
      do @(negedge clock);
      while (event_queue.size() != 0 || req_valid || predicted_reports.size() != 0);
   endtask

   task automatic start_hold();
      @(posedge clock);
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predicted_reports.push_back(profile_update(offered));
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (event_queue.size() != 0) begin
               offered = event_queue.pop_front();
               req_valid <= 1'b1;
               req_cmd <= offered.cmd;
               req_phase <= offered.phase;
               req_now_ticks <= offered.now_ticks;
               req_duration <= offered.duration;
               send_gap = idle_len(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
      end else if (hold_request) begin
         hold_count <= HOLD_CYCLES;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      phase_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_reports.size() == 0) begin
               $error("report transfer with no prediction waiting");
               fail_count++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("total_ticks", want.total_ticks, rsp_total_ticks);
               check_field("interval_count", 64'(want.interval_count),
                           64'(rsp_interval_count));
               check_field("longest_ticks", 64'(want.longest_ticks), 64'(rsp_longest_ticks));
               check_field("nest_depth", 64'(want.nest_depth), 64'(rsp_nest_depth));
               check_field("interval_closed", 64'(want.interval_closed),
                           64'(rsp_interval_closed));
               check_field("ignored", 64'(want.ignored), 64'(rsp_ignored));
               check_field("first_valid", 64'(want.first_valid), 64'(rsp_first_valid));
               check_field("first_time", 64'(want.first_time), 64'(rsp_first_time));
            end
         end
         if (hold_count != 0) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            recv_gap = idle_len(recv_calm);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [STAMP_W-1:0] t;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // tracking disabled: enter/exit ignored, accumulate still counts
      csr_write(1'b0);
      @(negedge clock);
      queue_event(npip_pkg::CMD_ENTER, 4'd0, 48'd10, 48'd0);
      queue_event(npip_pkg::CMD_EXIT, 4'd0, 48'd20, 48'd0);
      queue_event(npip_pkg::CMD_ACCUM, 4'd2, 48'hA5A5_5A5A_0F0F, 48'h8000_0000_0001);
      queue_event(npip_pkg::CMD_ACCUM, 4'd0, 48'd30, 48'd5);
      queue_event(npip_pkg::CMD_ACCUM, 4'd12, 48'd40, 48'd7);
      queue_event(npip_pkg::CMD_RSVD, 4'd1, 48'd50, 48'd0);
      wait_drained();

      csr_write(1'b1);
      @(negedge clock);
      queue_event(npip_pkg::CMD_ENTER, 4'd0, 48'd100, 48'd0);
      queue_event(npip_pkg::CMD_ENTER, 4'd0, 48'd200, 48'd0);
      queue_event(npip_pkg::CMD_EXIT, 4'd0, 48'd300, 48'd0);
      queue_event(npip_pkg::CMD_EXIT, 4'd0, 48'd50, 48'd0);
      queue_event(npip_pkg::CMD_ENTER, 4'd1, 48'd0, 48'd0);
      queue_event(npip_pkg::CMD_EXIT, 4'd1, STAMP_MAX, STAMP_MAX);
      queue_event(npip_pkg::CMD_ENTER, 4'd2, STAMP_MAX, 48'd0);
      queue_event(npip_pkg::CMD_EXIT, 4'd2, 48'd0, 48'd0);
      queue_event(npip_pkg::CMD_ACCUM, 4'd3, 48'd1, 48'h7FFF_FFFF_FFFF);
      queue_event(npip_pkg::CMD_ACCUM, 4'd3, 48'd2, 48'h8000_0000_0000);
      queue_event(npip_pkg::CMD_ACCUM, 4'd5, 48'd3, 48'd0);
      queue_event(npip_pkg::CMD_ACCUM, 4'd5, 48'd4, STAMP_MAX);
      queue_event(npip_pkg::CMD_EXIT, 4'd4, 48'd5, 48'd0);
      queue_event(npip_pkg::CMD_ACCUM, 4'd6, 48'd6, 48'd9);
      queue_event(npip_pkg::CMD_EXIT, 4'd15, 48'd7, 48'd0);
      queue_event(npip_pkg::CMD_ENTER, 4'd9, 48'd8, 48'd0);
      queue_event(npip_pkg::CMD_RSVD, 4'd3, 48'd9, 48'd0);
      queue_event(npip_pkg::CMD_RSVD, 4'd15, STAMP_MAX, STAMP_MAX);
      wait_drained();

      // nest past the depth limit while the receiver holds off
      start_hold();
      @(negedge clock);
      t = 48'h0000_1000_0000;
      repeat (257) begin
         queue_event(npip_pkg::CMD_ENTER, 4'd4, t, 48'd0);
         t = t + 48'd3;
      end
      repeat (3) begin
         queue_event(npip_pkg::CMD_EXIT, 4'd4, t, 48'd0);
         t = t + 48'd5;
      end
      wait_drained();

      start_hold();
      @(negedge clock);
      queue_random(60);
      wait_drained();

      csr_write(1'b0);
      @(negedge clock);
      queue_random(20);
      wait_drained();

      csr_write(1'b1);
      start_hold();
      @(negedge clock);
      queue_random(40);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
